@@ hw/rtl/gic_pkg.sv @@
// shared types and constants for the gamepad input conditioner
package gic_pkg;

  localparam int BUTTON_COUNT = 16;
  localparam logic [15:0] BUTTON_MASK = 16'((33'd1 << BUTTON_COUNT) - 33'd1);
  localparam logic [14:0] STICK_MAX = 15'd32767;

  localparam logic [1:0] CFG_LEFT_DZ  = 2'd0;
  localparam logic [1:0] CFG_RIGHT_DZ = 2'd1;
  localparam logic [1:0] CFG_TRIG_THR = 2'd2;

  localparam logic [1:0] LINK_NONE = 2'd0;
  localparam logic [1:0] LINK_UP   = 2'd1;
  localparam logic [1:0] LINK_DOWN = 2'd2;

  typedef struct packed {
    logic               link_up;
    logic [15:0]        button_bits;
    logic signed [15:0] left_x_raw;
    logic signed [15:0] left_y_raw;
    logic signed [15:0] right_x_raw;
    logic signed [15:0] right_y_raw;
    logic [7:0]         left_trigger_raw;
    logic [7:0]         right_trigger_raw;
  } gic_in_t;

  typedef struct packed {
    logic [1:0]         link_event;
    logic               sample_taken;
    logic [15:0]        pressed_mask;
    logic [15:0]        released_mask;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic [15:0]        left_trigger;
    logic [15:0]        right_trigger;
    logic               state_changed;
  } gic_out_t;

  // lane control: start pulse in, done pulse back
  typedef struct packed {
    logic start;
    logic done;
  } gic_lane_ctl_t;

endpackage

@@ hw/rtl/gamepad_input_conditioner.sv @@
// top level: link edges, button edges, stick and trigger lanes and merge
//
//   channel  | valid      | ready      | payload
//   ---------+------------+------------+------------------------
//   input    | in_valid   | in_ready   | in_word  (gic_in_t)
//   output   | out_valid  | out_ready  | out_word (gic_out_t)
//   config   | cfg_valid  | cfg_ready  | cfg_index, cfg_data
//
// one word at a time; a connected word waits on the stick lanes (24 root steps
// plus two 54-step serial divides) before the merge
// a disconnected word shows its result the cycle after it is taken
// the next input word is taken once the result has left the output register
// rst is synchronous and restores register defaults and the previous-sample state
module gamepad_input_conditioner import gic_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  gic_in_t     in_word,
  output logic        out_valid,
  input  logic        out_ready,
  output gic_out_t    out_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  typedef enum logic [1:0] {S_IDLE, S_RUN, S_MERGE} state_t;

  state_t      state;
  logic [14:0] left_dz, right_dz;
  logic [7:0]  trig_thr;
  logic        prev_link;
  logic [15:0] prev_buttons;
  logic [15:0] prev_st [4];
  logic [15:0] prev_tr [2];
  gic_in_t     cur;
  logic [3:0]  lane_done;
  logic        lane_start;

  gic_lane_ctl_t ctl_ls, ctl_rs, ctl_lt, ctl_rt;
  logic [15:0] lx, ly, rx, ry, lt, rt;
  logic [15:0] btn;
  logic        changed;

  assign cfg_ready = 1'b1;
  assign in_ready = (state == S_IDLE) && !out_valid;

  assign ctl_ls.start = lane_start;
  assign ctl_rs.start = lane_start;
  assign ctl_lt.start = lane_start;
  assign ctl_rt.start = lane_start;

  // four lanes run side by side on one sample
  gic_stick u_left (
    .clk(clk), .rst(rst), .start(ctl_ls.start), .x_raw(cur.left_x_raw),
    .y_raw(cur.left_y_raw), .radius(left_dz), .done(ctl_ls.done), .out_x(lx), .out_y(ly)
  );
  gic_stick u_right (
    .clk(clk), .rst(rst), .start(ctl_rs.start), .x_raw(cur.right_x_raw),
    .y_raw(cur.right_y_raw), .radius(right_dz), .done(ctl_rs.done), .out_x(rx), .out_y(ry)
  );
  gic_trigger u_ltrig (
    .clk(clk), .rst(rst), .start(ctl_lt.start), .raw(cur.left_trigger_raw),
    .thr(trig_thr), .done(ctl_lt.done), .value(lt)
  );
  gic_trigger u_rtrig (
    .clk(clk), .rst(rst), .start(ctl_rt.start), .raw(cur.right_trigger_raw),
    .thr(trig_thr), .done(ctl_rt.done), .value(rt)
  );

  // merge: compare against the last connected sample
  assign btn = cur.button_bits & BUTTON_MASK;
  assign changed = (btn != prev_buttons) || (lx != prev_st[0]) || (ly != prev_st[1])
                || (rx != prev_st[2]) || (ry != prev_st[3])
                || (lt != prev_tr[0]) || (rt != prev_tr[1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      lane_start <= 1'b0;
      lane_done <= '0;
      left_dz <= 15'd7849;
      right_dz <= 15'd8689;
      trig_thr <= 8'd30;
      prev_link <= 1'b0;
      prev_buttons <= '0;
      for (int i = 0; i < 4; i++) prev_st[i] <= '0;
      for (int i = 0; i < 2; i++) prev_tr[i] <= '0;
    end else begin
      lane_start <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_LEFT_DZ:  left_dz <= cfg_data[14:0];
          CFG_RIGHT_DZ: right_dz <= cfg_data[14:0];
          CFG_TRIG_THR: trig_thr <= cfg_data[7:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cur <= in_word;
            prev_link <= in_word.link_up;
            out_word <= '0;
            out_word.link_event <= (!prev_link && in_word.link_up) ? LINK_UP :
                                   (prev_link && !in_word.link_up) ? LINK_DOWN : LINK_NONE;
            if (in_word.link_up) begin
              lane_start <= 1'b1;
              lane_done <= '0;
              state <= S_RUN;
            end else begin
              out_valid <= 1'b1;
            end
          end
        end
        S_RUN: begin
          lane_done <= lane_done | {ctl_rt.done, ctl_lt.done, ctl_rs.done, ctl_ls.done};
          if (lane_done == 4'hF) state <= S_MERGE;
        end
        S_MERGE: begin
          out_word.sample_taken <= 1'b1;
          out_word.pressed_mask <= btn & ~prev_buttons;
          out_word.released_mask <= ~btn & prev_buttons;
          out_word.left_x <= lx;
          out_word.left_y <= ly;
          out_word.right_x <= rx;
          out_word.right_y <= ry;
          out_word.left_trigger <= lt;
          out_word.right_trigger <= rt;
          out_word.state_changed <= changed;
          prev_buttons <= btn;
          prev_st[0] <= lx; prev_st[1] <= ly; prev_st[2] <= rx; prev_st[3] <= ry;
          prev_tr[0] <= lt; prev_tr[1] <= rt;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ hw/rtl/gic_div.sv @@
// restoring divider, one quotient bit per cycle, 54 by 40 bits
module gic_div import gic_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [53:0] dividend,
  input  logic [39:0] divisor,
  output logic        done,
  output logic [53:0] quotient
);
  logic [40:0] rem;
  logic [53:0] quo;
  logic [5:0]  cnt;
  logic        busy;
  logic [40:0] trial;
  logic [40:0] shifted;

  assign shifted = {rem[39:0], quo[53]};
  assign trial = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
        rem  <= '0;
        quo  <= dividend;
      end else if (busy) begin
        if (!trial[40]) begin
          rem <= trial;
          quo <= {quo[52:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[52:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd53) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;
endmodule

@@ hw/rtl/gic_stick.sv @@
// one stick lane: clamp, radius test, square root, scaled direction by division
module gic_stick import gic_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] x_raw,
  input  logic signed [15:0] y_raw,
  input  logic [14:0]        radius,
  output logic               done,
  output logic [15:0]        out_x,
  output logic [15:0]        out_y
);
  typedef enum logic [2:0] {
    S_IDLE, S_SQ, S_ROOT, S_PREP, S_MULA, S_MULB, S_DIVX, S_DIVY
  } state_t;

  state_t      state;
  logic [14:0] ax, ay, r;
  logic        nx, ny;
  logic [30:0] s;
  logic [47:0] rad_rem;
  logic [24:0] root;
  logic [4:0]  cnt;
  logic [23:0] mc;
  logic [14:0] d;
  logic        dz_full;
  logic [39:0] den;
  logic [53:0] num;
  logic [53:0] qx;
  logic        zero_out;

  logic [14:0] ax_c, ay_c;
  logic [49:0] rtry;
  logic [47:0] rad_shift;
  logic        div_start, div_done;
  logic [53:0] div_quot;

  always_comb begin
    ax_c = (x_raw[15]) ? 15'(-(x_raw < -16'sd32767 ? -16'sd32767 : x_raw)) : x_raw[14:0];
    ay_c = (y_raw[15]) ? 15'(-(y_raw < -16'sd32767 ? -16'sd32767 : y_raw)) : y_raw[14:0];
  end

  // bit pair of s<<16 fed into the root, two radicand bits per cycle
  assign rad_shift = {rad_rem[45:0], 2'b00}
                   | 48'(2'(({1'b0, s, 16'd0} >> (6'd46 - {cnt, 1'b0}))));
  assign rtry = {2'b00, rad_shift} - {23'd0, root, 2'b01};

  gic_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(num), .divisor(den), .done(div_done), .quotient(div_quot)
  );

  assign div_start = (state == S_MULB) || (state == S_DIVX && div_done);

  function automatic logic [15:0] sat16(input logic neg, input logic [53:0] q);
    logic [14:0] m;
    m = (q > 54'(STICK_MAX)) ? STICK_MAX : q[14:0];
    return neg ? 16'(-{1'b0, m}) : {1'b0, m};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            ax <= ax_c; ay <= ay_c;
            nx <= x_raw[15]; ny <= y_raw[15];
            r  <= radius;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          s <= 31'(ax * ax) + 31'(ay * ay);
          rad_rem <= '0; root <= '0; cnt <= '0;
          d <= STICK_MAX - r;
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (!rtry[49]) begin
            rad_rem <= rtry[47:0];
            root <= {root[23:0], 1'b1};
          end else begin
            rad_rem <= rad_shift;
            root <= {root[23:0], 1'b0};
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'd23) state <= S_PREP;
        end
        S_PREP: begin
          zero_out <= (s < 31'(r * r)) || (root == '0);
          dz_full <= (d == '0);
          mc <= ((root[23:0] < {STICK_MAX, 8'd0}) ? root[23:0] : {STICK_MAX, 8'd0})
                - {1'b0, r, 8'd0};
          state <= S_MULA;
        end
        S_MULA: begin
          den <= dz_full ? 40'(root) : 40'(root[24:0] * d);
          num <= 54'(ax * (dz_full ? 24'd256 : mc)) * 54'(STICK_MAX);
          state <= S_MULB;
        end
        S_MULB: begin
          // divider takes the x dividend at this edge, y waits in num
          num <= 54'(ay * (dz_full ? 24'd256 : mc)) * 54'(STICK_MAX);
          state <= S_DIVX;
        end
        S_DIVX: begin
          if (div_done) begin
            qx  <= div_quot;
            state <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (div_done) begin
            out_x <= zero_out ? '0 : sat16(nx, qx);
            out_y <= zero_out ? '0 : sat16(ny, div_quot);
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ hw/rtl/gic_trigger.sv @@
// one trigger lane: threshold then rescale to q0.16 by a serial divide
module gic_trigger import gic_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [7:0]  raw,
  input  logic [7:0]  thr,
  output logic        done,
  output logic [15:0] value
);
  logic [23:0] quo;
  logic [8:0]  rem;
  logic [7:0]  den;
  logic [4:0]  cnt;
  logic        busy;
  logic [1:0]  mode;
  logic [8:0]  sh, trial;

  localparam logic [1:0] M_DIV = 2'd0, M_ZERO = 2'd1, M_FULL = 2'd2;

  assign sh = {rem[7:0], quo[23]};
  assign trial = sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        den  <= 8'd255 - thr;
        quo  <= 24'(16'(raw - thr) * 24'd65535);
        mode <= (raw < thr) ? M_ZERO : ((thr == 8'd255) ? M_FULL : M_DIV);
      end else if (busy) begin
        if (!trial[8]) begin
          rem <= trial;
          quo <= {quo[22:0], 1'b1};
        end else begin
          rem <= sh;
          quo <= {quo[22:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd23) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    case (mode)
      M_ZERO:  value = '0;
      M_FULL:  value = 16'hFFFF;
      default: value = quo[15:0];
    endcase
  end
endmodule

@@ tb/gamepad_input_conditioner_tb.sv @@
// self-checking testbench for the gamepad input conditioner: directed and random samples
module gamepad_input_conditioner_tb import gic_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // config index with no register behind it, writes must be dropped
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  // give a connected word room to finish before config writes
  localparam int unsigned SETTLE_CYCLES = 250;
  localparam longint unsigned FULL = 32767;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  gic_in_t     in_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  gic_out_t    out_word;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  gamepad_input_conditioner dut (
    .clk, .rst, .in_valid, .in_ready, .in_word, .out_valid, .out_ready, .out_word,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the block: registers and last connected sample
  logic [14:0] left_radius;
  logic [14:0] right_radius;
  logic [7:0]  trig_thr;
  logic        last_link;
  logic [15:0] last_buttons;
  logic [15:0] last_sticks [4];
  logic [15:0] last_triggers [2];

  gic_out_t expected_words [$];

  int unsigned sender_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  logic        long_stall_req = 1'b0;
  int unsigned stall_left = 0;

  // integer square root, one result bit per pair of input bits
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bit_pos;
    res = 0;
    bit_pos = 64'd1 << 62;
    while (bit_pos > v) bit_pos >>= 2;
    while (bit_pos != 0) begin
      if (v >= res + bit_pos) begin
        v -= res + bit_pos;
        res = (res >> 1) + bit_pos;
      end else begin
        res >>= 1;
      end
      bit_pos >>= 2;
    end
    return res;
  endfunction

  // saturate a magnitude and put the sign back in two's complement
  function automatic logic [15:0] signed_axis(logic neg, longint unsigned mag);
    if (mag > FULL) mag = FULL;
    return neg ? 16'(17'd65536 - 17'(mag)) : 16'(mag);
  endfunction

  // radial dead zone on one stick
  function automatic void dead_zone_stick(logic signed [15:0] xr, logic signed [15:0] yr,
                                          logic [14:0] r, output logic [15:0] ox,
                                          output logic [15:0] oy);
    int x, y;
    longint unsigned ax, ay, s, m, mc, d;
    x = xr;
    y = yr;
    if (x < -32767) x = -32767;
    if (y < -32767) y = -32767;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    s = ax * ax + ay * ay;
    ox = '0;
    oy = '0;
    if (s < longint'(r) * r) return;
    m = int_sqrt(s << 16);
    // centred stick with zero radius
    if (m == 0) return;
    d = FULL - r;
    if (d == 0) begin
      // radius at full scale: pure direction
      ox = signed_axis(x < 0, ax * FULL * 256 / m);
      oy = signed_axis(y < 0, ay * FULL * 256 / m);
      return;
    end
    mc = (m < (FULL << 8)) ? m : (FULL << 8);
    mc -= longint'(r) << 8;
    ox = signed_axis(x < 0, ax * FULL * mc / (m * d));
    oy = signed_axis(y < 0, ay * FULL * mc / (m * d));
  endfunction

  function automatic logic [15:0] scale_trigger(logic [7:0] raw, logic [7:0] thr);
    if (raw < thr) return '0;
    if (thr == 8'd255) return 16'hFFFF;
    return 16'((longint'(raw - thr) * 65535) / (255 - thr));
  endfunction

  // expected result of one accepted sample, advances the shadow state
  function automatic gic_out_t condition_sample(gic_in_t w);
    gic_out_t o;
    logic [15:0] btn;
    logic [15:0] st [4];
    logic [15:0] tr [2];
    logic chg;
    o = '0;
    if (!last_link && w.link_up) o.link_event = LINK_UP;
    else if (last_link && !w.link_up) o.link_event = LINK_DOWN;
    last_link = w.link_up;
    if (!w.link_up) return o;
    btn = w.button_bits & BUTTON_MASK;
    dead_zone_stick(w.left_x_raw, w.left_y_raw, left_radius, st[0], st[1]);
    dead_zone_stick(w.right_x_raw, w.right_y_raw, right_radius, st[2], st[3]);
    tr[0] = scale_trigger(w.left_trigger_raw, trig_thr);
    tr[1] = scale_trigger(w.right_trigger_raw, trig_thr);
    chg = (btn != last_buttons);
    for (int i = 0; i < 4; i++) if (st[i] != last_sticks[i]) chg = 1'b1;
    for (int i = 0; i < 2; i++) if (tr[i] != last_triggers[i]) chg = 1'b1;
    o.sample_taken = 1'b1;
    o.pressed_mask = btn & ~last_buttons;
    o.released_mask = ~btn & last_buttons;
    o.left_x = st[0];
    o.left_y = st[1];
    o.right_x = st[2];
    o.right_y = st[3];
    o.left_trigger = tr[0];
    o.right_trigger = tr[1];
    o.state_changed = chg;
    last_buttons = btn;
    for (int i = 0; i < 4; i++) last_sticks[i] = st[i];
    for (int i = 0; i < 2; i++) last_triggers[i] = tr[i];
    return o;
  endfunction

  // offer one word, predict it when the block takes it
  task automatic send_sample(gic_in_t w);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    expected_words.push_back(condition_sample(w));
  endtask

  // drain, let the block settle, then write one register
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_LEFT_DZ:  left_radius = data[14:0];
      CFG_RIGHT_DZ: right_radius = data[14:0];
      CFG_TRIG_THR: trig_thr = data[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [14:0] l, logic [14:0] r, logic [7:0] t);
    // random upper bits check the width masking
    write_reg(CFG_LEFT_DZ, {17'($urandom_range(131071)), l});
    write_reg(CFG_RIGHT_DZ, {17'($urandom_range(131071)), r});
    write_reg(CFG_TRIG_THR, {24'($urandom), t});
  endtask

  function automatic gic_in_t make_sample(logic link, logic [15:0] b,
                                          logic [15:0] lx, logic [15:0] ly,
                                          logic [15:0] rx, logic [15:0] ry,
                                          logic [7:0] lt, logic [7:0] rt);
    gic_in_t w;
    w.link_up = link;
    w.button_bits = b;
    w.left_x_raw = lx;
    w.left_y_raw = ly;
    w.right_x_raw = rx;
    w.right_y_raw = ry;
    w.left_trigger_raw = lt;
    w.right_trigger_raw = rt;
    return w;
  endfunction

  // axis value: sometimes near the dead zone edge or the rails, else anything
  function automatic logic [15:0] pick_axis(logic [14:0] r);
    int v;
    case ($urandom_range(5))
      0: v = $urandom_range(2 * r + 2) - r - 1;
      1: v = $urandom_range(1) ? 32767 - $urandom_range(3) : -32768 + $urandom_range(3);
      2: v = $urandom_range(300) - 150;
      default: v = $urandom;
    endcase
    return 16'(v);
  endfunction

  function automatic gic_in_t random_sample(logic [15:0] prev_b);
    gic_in_t w;
    w = make_sample($urandom_range(99) < 90,
                    $urandom_range(2) == 0 ? 16'($urandom) : prev_b ^ (16'd1 << $urandom_range(15)),
                    pick_axis(left_radius), pick_axis(left_radius),
                    pick_axis(right_radius), pick_axis(right_radius),
                    8'($urandom), 8'($urandom));
    // repeat a sample now and then so an unchanged state shows up
    if ($urandom_range(9) == 0) w.button_bits = prev_b;
    return w;
  endfunction

  task automatic test_directed();
    set_config(15'd7849, 15'd8689, 8'd30);
    send_sample(make_sample(1'b0, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 8'hFF, 8'hFF));
    send_sample(make_sample(1'b1, 16'hFFFF, 16'h7FFF, 16'h0000, 16'h8000, 16'h8000, 8'hFF, 8'h00));
    send_sample(make_sample(1'b1, 16'hFFFF, 16'h7FFF, 16'h0000, 16'h8000, 16'h8000, 8'hFF, 8'h00));
    send_sample(make_sample(1'b1, 16'h0000, 16'h8000, 16'h7FFF, 16'h0100, 16'hFF00, 8'd29, 8'd30));
    send_sample(make_sample(1'b1, 16'hA5A5, 16'd7849, 16'd0, 16'd0, 16'd8688, 8'd31, 8'd254));
    send_sample(make_sample(1'b0, 16'h5A5A, 16'h1234, 16'h4321, 16'h0, 16'h0, 8'd100, 8'd100));
    send_sample(make_sample(1'b0, 16'h0000, 16'h0, 16'h0, 16'h0, 16'h0, 8'd0, 8'd0));
    send_sample(make_sample(1'b1, 16'h5A5A, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd0, 8'd0));
    // zero radius: centred sticks have no magnitude, tiny deflections pass
    set_config(15'd0, 15'd0, 8'd0);
    send_sample(make_sample(1'b1, 16'h0001, 16'h0, 16'h0, 16'h0001, 16'hFFFF, 8'd0, 8'd255));
    send_sample(make_sample(1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 8'd1, 8'd128));
    // radius at full scale and threshold at full scale
    set_config(15'd32767, 15'd32767, 8'd255);
    send_sample(make_sample(1'b1, 16'h0, 16'h7FFF, 16'h0, 16'h8000, 16'h8000, 8'd255, 8'd254));
    send_sample(make_sample(1'b1, 16'hFFFF, 16'h5A82, 16'h5A82, 16'h7FFF, 16'h7FFF, 8'd255, 8'd255));
    send_sample(make_sample(1'b1, 16'hFFFF, 16'h1000, 16'h1000, 16'h0, 16'h0, 8'd0, 8'd255));
    // writes to the unused index change nothing
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    send_sample(make_sample(1'b1, 16'h00FF, 16'h7FFF, 16'h7FFF, 16'h8001, 16'h7FFF, 8'd255, 8'd0));
    send_sample(make_sample(1'b0, 16'h00FF, 16'h0, 16'h0, 16'h0, 16'h0, 8'd0, 8'd0));
  endtask

  task automatic test_random(int unsigned count);
    logic [15:0] b;
    gic_in_t w;
    b = 16'h0;
    for (int i = 0; i < count; i++) begin
      w = random_sample(b);
      b = w.button_bits;
      send_sample(w);
    end
  endtask

  // receiver holds off while words keep coming, so the input stalls
  task automatic test_backpressure();
    long_stall_req <= 1'b1;
    @(posedge clk);
    long_stall_req <= 1'b0;
    test_random(8);
  endtask

  initial begin
    left_radius = 15'd7849;
    right_radius = 15'd8689;
    trig_thr = 8'd30;
    last_link = 1'b0;
    last_buttons = '0;
    for (int i = 0; i < 4; i++) last_sticks[i] = '0;
    for (int i = 0; i < 2; i++) last_triggers[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();

    sender_idle_pct = 27;
    recv_idle_pct = 87;
    set_config(15'd7849, 15'd8689, 8'd30);
    test_random(300);
    test_backpressure();

    sender_idle_pct = 87;
    recv_idle_pct = 27;
    set_config(15'($urandom_range(32767)), 15'($urandom_range(2000)), 8'($urandom_range(255)));
    test_random(300);

    sender_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(15'($urandom_range(16000)), 15'd32766, 8'd254);
    test_random(150);
    set_config(15'd1, 15'($urandom_range(32767)), 8'd1);
    test_random(150);

    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // output side ready, with the occasional long hold-off
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (long_stall_req) begin
      stall_left <= 600;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each accepted result word with the oldest prediction
  always @(posedge clk) begin
    gic_out_t exp_w;
    logic bad;
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_word);
      end else begin
        exp_w = expected_words.pop_front();
        bad = (exp_w.link_event !== out_word.link_event) ||
              (exp_w.sample_taken !== out_word.sample_taken) ||
              (exp_w.pressed_mask !== out_word.pressed_mask) ||
              (exp_w.released_mask !== out_word.released_mask) ||
              (exp_w.left_x !== out_word.left_x) || (exp_w.left_y !== out_word.left_y) ||
              (exp_w.right_x !== out_word.right_x) || (exp_w.right_y !== out_word.right_y) ||
              (exp_w.left_trigger !== out_word.left_trigger) ||
              (exp_w.right_trigger !== out_word.right_trigger) ||
              (exp_w.state_changed !== out_word.state_changed);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("mismatch: expected ev=%0d tk=%0d pr=%h rl=%h",
                   exp_w.link_event, exp_w.sample_taken, exp_w.pressed_mask,
                   exp_w.released_mask);
            $display(" lx=%0d ly=%0d rx=%0d ry=%0d lt=%0d rt=%0d ch=%0d",
                     exp_w.left_x, exp_w.left_y, exp_w.right_x, exp_w.right_y,
                     exp_w.left_trigger, exp_w.right_trigger, exp_w.state_changed);
            $write("          actual   ev=%0d tk=%0d pr=%h rl=%h",
                   out_word.link_event, out_word.sample_taken, out_word.pressed_mask,
                   out_word.released_mask);
            $display(" lx=%0d ly=%0d rx=%0d ry=%0d lt=%0d rt=%0d ch=%0d",
                     out_word.left_x, out_word.left_y, out_word.right_x, out_word.right_y,
                     out_word.left_trigger, out_word.right_trigger, out_word.state_changed);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule
